FILE: src/sdve_pkg.sv
// Shared types and constants for the smoothed distance velocity estimator.
`timescale 1ns / 1ps

package sdve_pkg;

    localparam int HISTORY_DEPTH = 512;
    localparam int ADDR_W        = $clog2(HISTORY_DEPTH);
    localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);
    localparam int WIDE_W        = ((CNT_W > 10) ? CNT_W : 10) + 1;

    localparam int DIST_W   = 16;
    localparam int VEL_W    = 17;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [8:0]  RST_WEIGHT     = 9'd230;
    localparam logic [7:0]  RST_OUT_LIMIT  = 8'd3;
    localparam logic [8:0]  RST_SPAN       = 9'd10;
    localparam logic [15:0] RST_THRESHOLD  = 16'd128;
    localparam logic [9:0]  RST_HIST_LIMIT = 10'd500;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WEIGHT     = 3'd0,
        REG_OUT_LIMIT  = 3'd1,
        REG_SPAN       = 3'd2,
        REG_THRESHOLD  = 3'd3,
        REG_HIST_LIMIT = 3'd4
    } t_cfg_reg;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DIST_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_ring_req;

endpackage

FILE: src/smoothed_distance_velocity_estimator.sv
// Top level of the smoothed distance velocity estimator.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one distance sample per
//   request. Output channel (o_out_valid / i_out_ready) returns exactly one
//   result per sample: velocity, velocity_valid and history_restarted.
//   Configuration channel (i_cfg_valid / o_cfg_ready) writes one register per
//   request; it is always ready. Write it only while no sample is in flight.
// Timing:
//   Three-stage pipeline: input register, history update with ring read,
//   output register. One request is taken every cycle while the receiver
//   keeps i_out_ready high. The history ring's read port is registered and
//   feeds the output register.
// Reset:
//   Empties the history, clears the outlier run and loads register defaults.
//   Ring contents are not cleared; only entries written since are read.
// Stall:
//   When the receiver holds i_out_ready low, the result stays in the output
//   register and the stages behind it fill; o_in_ready drops once all three
//   stages hold a sample.
`timescale 1ns / 1ps

module smoothed_distance_velocity_estimator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [sdve_pkg::DIST_W-1:0]    i_distance,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic signed [sdve_pkg::VEL_W-1:0] o_velocity,
    output logic                           o_velocity_valid,
    output logic                           o_history_restarted,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [sdve_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sdve_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import sdve_pkg::*;

    // configuration
    logic [8:0]  r_weight;
    logic [7:0]  r_out_limit;
    logic [8:0]  r_span;
    logic [15:0] r_threshold;
    logic [9:0]  r_hist_limit;

    // history state
    logic [ADDR_W-1:0] r_slot, n_slot;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [7:0]        r_run, n_run;
    logic [DIST_W-1:0] r_newest, n_newest;

    // pipeline
    logic              r_s1_v;
    logic [DIST_W-1:0] r_s1_dist;
    logic              r_s2_v;
    logic [DIST_W-1:0] r_s2_newest;
    logic              r_s2_vvalid;
    logic              r_s2_same;
    logic              r_s2_restart;
    logic              r_out_v;
    logic signed [VEL_W-1:0] r_velocity;
    logic              r_vvalid;
    logic              r_restart;

    logic s3_ready, s2_ready, s1_go, in_accept;

    // stage 1 datapath
    logic [8:0]        w9, wc9;
    logic [24:0]       prod_a, prod_b;
    logic [25:0]       acc;
    logic [DIST_W-1:0] smoothed, jump;
    logic              outlier;
    logic [7:0]        run_inc;
    logic [WIDE_W-1:0] lim, count_inc, span_w, back_w, slot_w, old_w;
    logic [8:0]        span9;
    logic              n_restart, n_vvalid, n_same;
    logic [DIST_W-1:0] rd_data, older;
    t_ring_req         ring_req;

    assign s3_ready   = !r_out_v || i_out_ready;
    assign s2_ready   = !r_s2_v || s3_ready;
    assign s1_go      = r_s1_v && s2_ready;
    assign o_in_ready = !r_s1_v || s2_ready;
    assign in_accept  = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        w9     = (r_weight > 9'd256) ? 9'd256 : r_weight;
        wc9    = 9'd256 - w9;
        prod_a = 25'(w9) * 25'(r_newest);
        prod_b = 25'(wc9) * 25'(r_s1_dist);
        acc    = {1'b0, prod_a} + {1'b0, prod_b} + 26'd128;
        smoothed = acc[23:8];
        jump   = (smoothed > r_newest) ? smoothed - r_newest : r_newest - smoothed;
        outlier = jump > r_threshold;
        run_inc = r_run + 8'd1;

        lim = WIDE_W'(r_hist_limit);
        if (lim == '0) begin
            lim = WIDE_W'(1);
        end
        if (lim > WIDE_W'(HISTORY_DEPTH)) begin
            lim = WIDE_W'(HISTORY_DEPTH);
        end
        count_inc = WIDE_W'(r_count) + WIDE_W'(1);

        n_slot    = r_slot;
        n_count   = r_count;
        n_run     = r_run;
        n_newest  = r_newest;
        n_restart = 1'b0;
        ring_req.we    = 1'b0;
        ring_req.waddr = '0;
        ring_req.wdata = smoothed;

        if (r_count == '0) begin
            n_slot         = '0;
            n_count        = CNT_W'(1);
            n_run          = '0;
            n_newest       = '0;
            ring_req.we    = 1'b1;
            ring_req.wdata = '0;
        end else if (outlier) begin
            n_run = run_inc;
            if (run_inc >= r_out_limit) begin
                n_slot      = '0;
                n_count     = CNT_W'(1);
                n_run       = '0;
                n_newest    = smoothed;
                n_restart   = 1'b1;
                ring_req.we = 1'b1;
            end
        end else begin
            n_run    = '0;
            n_slot   = (r_slot == ADDR_W'(HISTORY_DEPTH - 1)) ? '0 : r_slot + ADDR_W'(1);
            n_count  = (count_inc > lim) ? CNT_W'(lim) : CNT_W'(count_inc);
            n_newest = smoothed;
            ring_req.we    = 1'b1;
            ring_req.waddr = n_slot;
        end
        ring_req.we = ring_req.we && s1_go;

        span9    = (r_span == '0) ? 9'd1 : r_span;
        span_w   = WIDE_W'(span9);
        back_w   = span_w - WIDE_W'(1);
        n_vvalid = WIDE_W'(n_count) > span_w;
        n_same   = back_w == '0;
        slot_w   = WIDE_W'(n_slot);
        old_w    = (slot_w >= back_w) ? slot_w - back_w
                                      : slot_w + WIDE_W'(HISTORY_DEPTH) - back_w;
        ring_req.re    = s1_go && n_vvalid && !n_same;
        ring_req.raddr = old_w[ADDR_W-1:0];
    end

    sdve_ring u_ring (
        .i_clk     (i_clk),
        .i_req     (ring_req),
        .o_rd_data (rd_data)
    );

    assign older = r_s2_same ? r_s2_newest : rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight     <= RST_WEIGHT;
            r_out_limit  <= RST_OUT_LIMIT;
            r_span       <= RST_SPAN;
            r_threshold  <= RST_THRESHOLD;
            r_hist_limit <= RST_HIST_LIMIT;
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_WEIGHT:     r_weight     <= i_cfg_data[8:0];
                REG_OUT_LIMIT:  r_out_limit  <= i_cfg_data[7:0];
                REG_SPAN:       r_span       <= i_cfg_data[8:0];
                REG_THRESHOLD:  r_threshold  <= i_cfg_data[15:0];
                REG_HIST_LIMIT: r_hist_limit <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot  <= '0;
            r_count <= '0;
            r_run   <= '0;
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (in_accept) begin
                r_s1_v <= 1'b1;
            end else if (s1_go) begin
                r_s1_v <= 1'b0;
            end
            if (s1_go) begin
                r_slot  <= n_slot;
                r_count <= n_count;
                r_run   <= n_run;
            end
            if (s2_ready) begin
                r_s2_v <= r_s1_v;
            end
            if (s3_ready) begin
                r_out_v <= r_s2_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_dist <= i_distance;
        end
        if (s1_go) begin
            r_newest     <= n_newest;
            r_s2_newest  <= n_newest;
            r_s2_vvalid  <= n_vvalid;
            r_s2_same    <= n_same;
            r_s2_restart <= n_restart;
        end
        if (s3_ready && r_s2_v) begin
            r_velocity <= r_s2_vvalid ? VEL_W'({1'b0, older} - {1'b0, r_s2_newest}) : '0;
            r_vvalid   <= r_s2_vvalid;
            r_restart  <= r_s2_restart;
        end
    end

    assign o_out_valid         = r_out_v;
    assign o_velocity          = r_velocity;
    assign o_velocity_valid    = r_vvalid;
    assign o_history_restarted = r_restart;

    a_vel_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_velocity_valid |-> o_velocity == '0)
        else $error("velocity nonzero without valid flag");

    a_restart_novalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_history_restarted |-> !o_velocity_valid)
        else $error("restart result carries a valid velocity");

    a_restart_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_go && n_restart |=> r_count == CNT_W'(1))
        else $error("history not reset to one entry on restart");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        WIDE_W'(r_count) <= WIDE_W'(HISTORY_DEPTH))
        else $error("entry count exceeds ring depth");

    a_stage_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_go |=> r_s2_v)
        else $error("stage two lost a request");

endmodule

FILE: src/sdve_ring.sv
// History ring memory: one write port, one registered read port.
`timescale 1ns / 1ps

module sdve_ring (
    input  logic                        i_clk,
    input  sdve_pkg::t_ring_req         i_req,
    output logic [sdve_pkg::DIST_W-1:0] o_rd_data
);
    import sdve_pkg::*;

    logic [DIST_W-1:0] mem [HISTORY_DEPTH];
    logic [DIST_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rd_data <= mem[i_req.raddr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: sim/smoothed_distance_velocity_estimator_tb.sv
// Self-checking testbench for the smoothed distance velocity estimator.
`timescale 1ns / 1ps

module smoothed_distance_velocity_estimator_tb;
    import sdve_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic signed [VEL_W-1:0] velocity;
        logic                    velocity_valid;
        logic                    history_restarted;
    } t_vel_res;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_SAMPLE,
        ROW_SAMPLE_KNOWN
    } t_row_kind;

    typedef struct packed {
        t_row_kind               kind;
        logic [CFG_IDX_W-1:0]    idx;
        logic [15:0]             value;
        logic signed [VEL_W-1:0] velocity;
        logic                    velocity_valid;
        logic                    history_restarted;
    } t_plan_row;

    localparam int PLAN_LEN = 34;
    localparam t_plan_row PLAN [PLAN_LEN] = '{
        '{ROW_SAMPLE_KNOWN, REG_WEIGHT,     16'h1234, 17'sd0,      1'b0, 1'b0},
        '{ROW_SAMPLE,       REG_WEIGHT,     16'hFFFF, 17'sd0,      1'b0, 1'b0},
        '{ROW_SAMPLE,       REG_WEIGHT,     16'hFFFF, 17'sd0,      1'b0, 1'b0},
        '{ROW_SAMPLE_KNOWN, REG_WEIGHT,     16'hFFFF, 17'sd0,      1'b0, 1'b1},
        '{ROW_CFG,          REG_WEIGHT,     16'd0,    17'sd0,      1'b0, 1'b0},
        '{ROW_CFG,          REG_THRESHOLD,  16'hFFFF, 17'sd0,      1'b0, 1'b0},
        '{ROW_CFG,          REG_SPAN,       16'd1,    17'sd0,      1'b0, 1'b0},
        '{ROW_SAMPLE_KNOWN, REG_WEIGHT,     16'h0000, 17'sd0,      1'b1, 1'b0},
        '{ROW_CFG,          REG_SPAN,       16'd2,    17'sd0,      1'b0, 1'b0},
        '{ROW_SAMPLE_KNOWN, REG_WEIGHT,     16'hFFFF, -17'sd65535, 1'b1, 1'b0},
        '{ROW_SAMPLE_KNOWN, REG_WEIGHT,     16'h0000, 17'sd65535,  1'b1, 1'b0},
        '{ROW_CFG,          REG_THRESHOLD,  16'd0,    17'sd0,      1'b0, 1'b0},
        '{ROW_CFG,          REG_OUT_LIMIT,  16'd0,    17'sd0,      1'b0, 1'b0},
        '{ROW_SAMPLE_KNOWN, REG_WEIGHT,     16'h8000, 17'sd0,      1'b0, 1'b1},
        '{ROW_SAMPLE_KNOWN, REG_WEIGHT,     16'h8000, 17'sd0,      1'b0, 1'b0},
        '{ROW_CFG,          REG_WEIGHT,     16'd511,  17'sd0,      1'b0, 1'b0},
        '{ROW_CFG,          REG_THRESHOLD,  16'd128,  17'sd0,      1'b0, 1'b0},
        '{ROW_CFG,          REG_OUT_LIMIT,  16'd255,  17'sd0,      1'b0, 1'b0},
        '{ROW_CFG,          REG_SPAN,       16'd0,    17'sd0,      1'b0, 1'b0},
        '{ROW_CFG,          REG_HIST_LIMIT, 16'd0,    17'sd0,      1'b0, 1'b0},
        '{ROW_SAMPLE_KNOWN, REG_WEIGHT,     16'h0000, 17'sd0,      1'b0, 1'b0},
        '{ROW_SAMPLE_KNOWN, REG_WEIGHT,     16'hFFFF, 17'sd0,      1'b0, 1'b0},
        '{ROW_CFG,          REG_HIST_LIMIT, 16'd1023, 17'sd0,      1'b0, 1'b0},
        '{ROW_CFG,          REG_WEIGHT,     16'd256,  17'sd0,      1'b0, 1'b0},
        '{ROW_CFG,          REG_UNUSED_HI,  16'hFFFF, 17'sd0,      1'b0, 1'b0},
        '{ROW_CFG,          REG_UNUSED_LO,  16'h0000, 17'sd0,      1'b0, 1'b0},
        '{ROW_SAMPLE_KNOWN, REG_WEIGHT,     16'h1111, 17'sd0,      1'b1, 1'b0},
        '{ROW_CFG,          REG_WEIGHT,     16'd128,  17'sd0,      1'b0, 1'b0},
        '{ROW_CFG,          REG_SPAN,       16'd511,  17'sd0,      1'b0, 1'b0},
        '{ROW_CFG,          REG_HIST_LIMIT, 16'd2,    17'sd0,      1'b0, 1'b0},
        '{ROW_CFG,          REG_OUT_LIMIT,  16'd1,    17'sd0,      1'b0, 1'b0},
        '{ROW_SAMPLE,       REG_WEIGHT,     16'h0100, 17'sd0,      1'b0, 1'b0},
        '{ROW_SAMPLE,       REG_WEIGHT,     16'hFF00, 17'sd0,      1'b0, 1'b0},
        '{ROW_SAMPLE,       REG_WEIGHT,     16'h00FF, 17'sd0,      1'b0, 1'b0}
    };

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_ready;
    logic [DIST_W-1:0]       i_distance = '0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    logic signed [VEL_W-1:0] o_velocity;
    logic                    o_velocity_valid;
    logic                    o_history_restarted;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data = '0;

    smoothed_distance_velocity_estimator uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_distance          (i_distance),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_velocity          (o_velocity),
        .o_velocity_valid    (o_velocity_valid),
        .o_history_restarted (o_history_restarted),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the history and registers.
    logic [DIST_W-1:0] hist_ring [HISTORY_DEPTH];
    logic [ADDR_W-1:0] hist_newest = '0;
    int unsigned       hist_count = 0;
    logic [7:0]        outlier_run_cnt = '0;
    logic [8:0]        cfg_weight = RST_WEIGHT;
    logic [7:0]        cfg_out_limit = RST_OUT_LIMIT;
    logic [8:0]        cfg_span = RST_SPAN;
    logic [15:0]       cfg_threshold = RST_THRESHOLD;
    logic [9:0]        cfg_hist_limit = RST_HIST_LIMIT;

    t_vel_res velocity_expect_q [$];
    t_vel_res head_result;
    int       mismatches = 0;
    int       idle_cycles = 0;
    int       burst_left = 0;
    int       rx_left = 0;
    int       rx_mode = 0;

    function automatic t_vel_res step_history(logic [DIST_W-1:0] sample_val);
        t_vel_res    r;
        int unsigned w, prev, sm, jump, lim, span, old_slot;
        logic [DIST_W-1:0] older, newest;
        r = '0;
        if (hist_count > 0) begin
            w = (cfg_weight > 256) ? 256 : cfg_weight;
            prev = hist_ring[hist_newest];
            sm = (w * prev + (256 - w) * sample_val + 128) >> 8;
            jump = (sm > prev) ? sm - prev : prev - sm;
            if (jump > cfg_threshold) begin
                outlier_run_cnt = outlier_run_cnt + 8'd1;
                if (outlier_run_cnt >= cfg_out_limit) begin
                    hist_newest = '0;
                    hist_ring[0] = 16'(sm);
                    hist_count = 1;
                    outlier_run_cnt = '0;
                    r.history_restarted = 1'b1;
                end
            end else begin
                lim = (cfg_hist_limit < 1) ? 1 :
                      (cfg_hist_limit > HISTORY_DEPTH) ? HISTORY_DEPTH : cfg_hist_limit;
                outlier_run_cnt = '0;
                hist_newest = hist_newest + 1'b1;
                hist_ring[hist_newest] = 16'(sm);
                hist_count = (hist_count + 1 > lim) ? lim : hist_count + 1;
            end
        end else begin
            outlier_run_cnt = '0;
            hist_newest = '0;
            hist_ring[0] = '0;
            hist_count = 1;
        end
        span = (cfg_span == 0) ? 1 : cfg_span;
        if (hist_count > span) begin
            old_slot = (hist_newest + HISTORY_DEPTH - (span - 1)) % HISTORY_DEPTH;
            older = hist_ring[old_slot];
            newest = hist_ring[hist_newest];
            r.velocity = {1'b0, older} - {1'b0, newest};
            r.velocity_valid = 1'b1;
        end
        return r;
    endfunction

    task automatic report_mismatch(string field, logic signed [31:0] got,
                                   logic signed [31:0] want);
        $display("%0t: %s mismatch, got %0d expected %0d", $time, field, got, want);
        mismatches++;
    endtask

    task automatic send_sample(logic [DIST_W-1:0] sample_val, bit known, t_vel_res known_res);
        t_vel_res pred;
        i_in_valid <= 1'b1;
        i_distance <= sample_val;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pred = step_history(sample_val);
        velocity_expect_q.push_back(known ? known_res : pred);
    endtask

    // Burst accounting for the sample channel.
    task automatic pace();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
                                                     : $urandom_range(0, 6);
        end
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (velocity_expect_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
        logic [15:0] data;
        data = 16'($urandom);
        case (idx)
            REG_WEIGHT:     data[8:0] = value[8:0];
            REG_OUT_LIMIT:  data[7:0] = value[7:0];
            REG_SPAN:       data[8:0] = value[8:0];
            REG_HIST_LIMIT: data[9:0] = value[9:0];
            default:        data = value;
        endcase
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            REG_WEIGHT:     cfg_weight = data[8:0];
            REG_OUT_LIMIT:  cfg_out_limit = data[7:0];
            REG_SPAN:       cfg_span = data[8:0];
            REG_THRESHOLD:  cfg_threshold = data;
            REG_HIST_LIMIT: cfg_hist_limit = data[9:0];
            default:        ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Receiver: free-running, choppy or long-stall runs.
    always @(posedge i_clk) begin
        if (rx_left > 0) begin
            rx_left <= rx_left - 1;
        end else if (i_out_ready) begin
            if (rx_mode == 0) begin
                rx_left <= $urandom_range(0, 60);
                rx_mode <= $urandom_range(0, 2);
            end else begin
                i_out_ready <= 1'b0;
                rx_left <= (rx_mode == 1) ? $urandom_range(0, 2) : $urandom_range(4, 19);
            end
        end else begin
            i_out_ready <= 1'b1;
            rx_left <= (rx_mode == 1) ? $urandom_range(0, 2) : $urandom_range(0, 9);
            rx_mode <= $urandom_range(0, 2);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (velocity_expect_q.size() == 0) begin
                report_mismatch("unrequested result velocity", o_velocity, 0);
            end else begin
                head_result = velocity_expect_q.pop_front();
                if (o_velocity !== head_result.velocity)
                    report_mismatch("velocity", o_velocity, head_result.velocity);
                if (o_velocity_valid !== head_result.velocity_valid)
                    report_mismatch("velocity_valid", o_velocity_valid,
                                    head_result.velocity_valid);
                if (o_history_restarted !== head_result.history_restarted)
                    report_mismatch("history_restarted", o_history_restarted,
                                    head_result.history_restarted);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("smoothed_distance_velocity_estimator regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        t_vel_res    known_res;
        int          n_items, track, step, r, pick;
        logic [15:0] sample_val;
        track = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < PLAN_LEN; i++) begin
            if (PLAN[i].kind == ROW_CFG) begin
                drain_results();
                cfg_write(PLAN[i].idx, PLAN[i].value);
            end else begin
                known_res.velocity = PLAN[i].velocity;
                known_res.velocity_valid = PLAN[i].velocity_valid;
                known_res.history_restarted = PLAN[i].history_restarted;
                send_sample(PLAN[i].value, PLAN[i].kind == ROW_SAMPLE_KNOWN, known_res);
                pace();
            end
        end

        // First phase fills and wraps the whole ring; the rest are short.
        for (int ph = 0; ph < 9; ph++) begin
            drain_results();
            if (ph == 0) begin
                cfg_write(REG_SPAN, ($urandom_range(0, 1) == 1) ? 16'd511
                                                                : 16'($urandom_range(450, 510)));
                cfg_write(REG_THRESHOLD, 16'hFFFF);
                cfg_write(REG_HIST_LIMIT, 16'($urandom_range(512, 1023)));
                cfg_write(REG_WEIGHT, 16'($urandom_range(0, 256)));
                n_items = 530;
            end else begin
                pick = $urandom_range(0, 3);
                cfg_write(REG_WEIGHT, (pick == 0) ? 16'd0 :
                                      (pick == 1) ? 16'($urandom_range(256, 511)) :
                                                    16'($urandom_range(0, 255)));
                cfg_write(REG_OUT_LIMIT, ($urandom_range(0, 3) == 0) ?
                                         16'($urandom_range(0, 255)) :
                                         16'($urandom_range(1, 4)));
                cfg_write(REG_SPAN, ($urandom_range(0, 5) == 0) ? 16'($urandom_range(0, 511))
                                                                : 16'($urandom_range(0, 12)));
                pick = $urandom_range(0, 4);
                cfg_write(REG_THRESHOLD, (pick == 0) ? 16'd0 :
                                         (pick == 1) ? 16'hFFFF :
                                         (pick == 2) ? 16'($urandom) :
                                                       16'($urandom_range(0, 1024)));
                cfg_write(REG_HIST_LIMIT, ($urandom_range(0, 5) == 0) ?
                                          16'($urandom_range(0, 1023)) :
                                          16'($urandom_range(2, 24)));
                if ($urandom_range(0, 3) == 0)
                    cfg_write(3'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)), 16'($urandom));
                n_items = $urandom_range(8, 24);
            end
            step = (cfg_threshold == 0) ? 2 : (cfg_threshold > 2048) ? 2048 : cfg_threshold;
            for (int k = 0; k < n_items; k++) begin
                r = $urandom_range(0, 99);
                if (r < 75)
                    track = track + int'($urandom_range(0, 2 * step)) - step;
                else if (r < 92)
                    track = $urandom_range(0, 65535);
                if (track < 0) track = 0;
                if (track > 65535) track = 65535;
                sample_val = (r >= 92) ? 16'($urandom) : 16'(track);
                send_sample(sample_val, 1'b0, '0);
                pace();
            end
        end

        drain_results();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0)
            $display("smoothed_distance_velocity_estimator regression: pass");
        else
            $display("smoothed_distance_velocity_estimator regression: fail");
        $finish;
    end

endmodule
